>>> hdl/ps2kmd_pkg.sv
// Package for the PS/2 keyboard and mouse byte decoder.
// Holds the scan codes, packet phase codes, register indexes and payload types.
// No dependencies.
package ps2kmd_pkg;

	// mouse header sync bit and keyboard codes
	localparam logic [7:0] HDR_SYNC_MASK  = 8'h08;
	localparam logic [7:0] KB_EXT_PREFIX  = 8'hE0;
	localparam logic [7:0] KB_F5_MAKE     = 8'h3F;
	localparam logic [7:0] KB_F5_BREAK    = 8'hBF;
	localparam int         KB_BREAK_BIT   = 7;
	localparam logic [7:0] KB_UP_MAKE     = 8'h48;
	localparam logic [7:0] KB_DOWN_MAKE   = 8'h50;
	localparam logic [7:0] KB_LEFT_MAKE   = 8'h4B;
	localparam logic [7:0] KB_RIGHT_MAKE  = 8'h4D;
	localparam logic [7:0] KB_UP_BREAK    = 8'hC8;
	localparam logic [7:0] KB_DOWN_BREAK  = 8'hD0;
	localparam logic [7:0] KB_LEFT_BREAK  = 8'hCB;
	localparam logic [7:0] KB_RIGHT_BREAK = 8'hCD;

	// mouse packet phases
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_DX     = 2'd1;
	localparam logic [1:0] PH_DY     = 2'd2;

	// configuration register indexes
	localparam int              CFG_IDX_W     = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_Y = 2'd1;
	localparam logic [9:0]      MAX_X_RESET   = 10'd1023;
	localparam logic [9:0]      MAX_Y_RESET   = 10'd767;

	typedef struct packed {
		logic       from_mouse;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [9:0] cursor_x;
		logic [9:0] cursor_y;
		logic       left_button;
		logic [6:0] key_code;
		logic       packet_done;
	} result_t;

endpackage

>>> hdl/ps2kmd_in_stage.sv
// Input register of the PS/2 byte decoder: holds one accepted byte.
// Depends on ps2kmd_pkg.
module ps2kmd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ps2kmd_pkg::item_t in_item,
	output logic              item_valid,
	input  logic              item_take,
	output ps2kmd_pkg::item_t item
);
	import ps2kmd_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	// free when empty or when the held byte moves on this cycle
	assign in_ready   = !valid_s1 || item_take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> hdl/ps2kmd_core.sv
// Decode state of the PS/2 byte decoder: mouse packet tracking, cursor
// clamp, key and button tracking. Depends on ps2kmd_pkg.
module ps2kmd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  ps2kmd_pkg::item_t   item,
	input  logic [9:0]          max_x,
	input  logic [9:0]          max_y,
	output ps2kmd_pkg::result_t result
);
	import ps2kmd_pkg::*;

	logic [1:0] phase_q, phase_d;
	logic [7:0] header_q, header_d;
	logic [7:0] dx_q, dx_d;
	logic [9:0] pos_x_q, pos_x_d;
	logic [9:0] pos_y_q, pos_y_d;
	logic       button_q, button_d;
	logic [6:0] key_q, key_d;
	logic       ext_q, ext_d;
	logic       done;

	logic [7:0]  b;
	logic [11:0] sum_x;
	logic [11:0] sum_y;
	logic [9:0]  clamp_x;
	logic [9:0]  clamp_y;

	assign b = item.data_byte;

	// cursor update, 12 bits signed covers both directions
	assign sum_x = {2'b00, pos_x_q} + {{4{dx_q[7]}}, dx_q};
	assign sum_y = {2'b00, pos_y_q} - {{4{b[7]}}, b};

	// clamp each axis to zero and its maximum
	always_comb begin
		if (sum_x[11]) begin
			clamp_x = 10'd0;
		end else if (sum_x[10:0] > {1'b0, max_x}) begin
			clamp_x = max_x;
		end else begin
			clamp_x = sum_x[9:0];
		end
		if (sum_y[11]) begin
			clamp_y = 10'd0;
		end else if (sum_y[10:0] > {1'b0, max_y}) begin
			clamp_y = max_y;
		end else begin
			clamp_y = sum_y[9:0];
		end
	end

	// next state for one byte
	always_comb begin
		phase_d  = phase_q;
		header_d = header_q;
		dx_d     = dx_q;
		pos_x_d  = pos_x_q;
		pos_y_d  = pos_y_q;
		button_d = button_q;
		key_d    = key_q;
		ext_d    = ext_q;
		done     = 1'b0;
		if (item.from_mouse) begin
			case (phase_q)
				PH_DX: begin
					dx_d    = b;
					phase_d = PH_DY;
				end
				PH_DY: begin
					phase_d  = PH_HEADER;
					button_d = header_q[0];
					pos_x_d  = clamp_x;
					pos_y_d  = clamp_y;
					done     = 1'b1;
				end
				default: begin
					// header phase, and the unused code treated alike
					phase_d = PH_HEADER;
					if ((b & HDR_SYNC_MASK) != 8'h00) begin
						header_d = b;
						phase_d  = PH_DX;
					end
				end
			endcase
		end else if (b == KB_EXT_PREFIX) begin
			ext_d = 1'b1;
		end else if (ext_q) begin
			// extended byte: only arrow keys matter
			if (b == KB_UP_MAKE || b == KB_DOWN_MAKE || b == KB_LEFT_MAKE
			    || b == KB_RIGHT_MAKE) begin
				key_d = b[6:0];
			end else if (b == KB_UP_BREAK || b == KB_DOWN_BREAK
			             || b == KB_LEFT_BREAK || b == KB_RIGHT_BREAK) begin
				key_d = 7'd0;
			end
			ext_d = 1'b0;
		end else if (b == KB_F5_MAKE) begin
			button_d = 1'b1;
		end else if (b == KB_F5_BREAK) begin
			button_d = 1'b0;
		end else if (!b[KB_BREAK_BIT]) begin
			key_d = b[6:0];
		end else begin
			key_d = 7'd0;
		end
	end

	// result built from the updated state
	always_comb begin
		result.cursor_x    = pos_x_d;
		result.cursor_y    = pos_y_d;
		result.left_button = button_d;
		result.key_code    = key_d;
		result.packet_done = done;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			header_q <= 8'd0;
			dx_q     <= 8'd0;
			pos_x_q  <= 10'd0;
			pos_y_q  <= 10'd0;
			button_q <= 1'b0;
			key_q    <= 7'd0;
			ext_q    <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			header_q <= header_d;
			dx_q     <= dx_d;
			pos_x_q  <= pos_x_d;
			pos_y_q  <= pos_y_d;
			button_q <= button_d;
			key_q    <= key_d;
			ext_q    <= ext_d;
		end
	end

endmodule

>>> hdl/ps2kmd_out_stage.sv
// Output register of the PS/2 byte decoder: holds one result until taken.
// Depends on ps2kmd_pkg.
module ps2kmd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	output logic                res_fire,
	input  ps2kmd_pkg::result_t res,
	output logic                out_valid,
	input  logic                out_ready,
	output ps2kmd_pkg::result_t out_res
);
	import ps2kmd_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	// load when empty or when the held result leaves this cycle
	assign res_fire  = res_valid && (!valid_s2 || out_ready);
	assign out_valid = valid_s2;
	assign out_res   = res_s2;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= res_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (res_fire) begin
			res_s2 <= res;
		end
	end

endmodule

>>> hdl/ps2_keyboard_mouse_byte_decoder.sv
// PS/2 keyboard and mouse byte decoder, top level.
// Uses ps2kmd_pkg, ps2kmd_in_stage, ps2kmd_core and ps2kmd_out_stage.
//
// Usage:
//   s_* stream: one controller byte per transaction, s_tuser marks a mouse
//   byte (1) or a keyboard byte (0).
//   m_* stream: one result per input byte with cursor, button and key state;
//   m_tuser is high when the byte closed a three byte mouse packet.
//   cfg_* channel: writes max_x (index 0) and max_y (index 1), always ready;
//   write only while no byte is in flight.
// Datapath: input register, then decode into the output register.
// Throughput: one byte per cycle while the output is not stalled. The decode
//   state updates as each byte is decoded, so the next byte reads it right away.
// Reset: cursor at 0,0, button and key clear, packet phase waiting for a
//   header, max_x 1023 and max_y 767.
// Stall: while m_tready is low the result holds; one more byte is taken
//   into the input register, then s_tready drops until the result leaves.
module ps2_keyboard_mouse_byte_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [7:0] data_byte
	input  logic                             s_tuser,   // [0] from_mouse
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [9:0] cursor_x, [19:10] cursor_y, [20] left_button,
	// [27:21] key_code, [31:28] zero
	output logic [31:0]                      m_tdata,
	output logic                             m_tuser,   // [0] packet_done
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ps2kmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [9:0]                       cfg_data
);
	import ps2kmd_pkg::*;

	logic    item_valid;
	logic    fire;
	item_t   in_item;
	item_t   item;
	result_t res;
	result_t out_res;
	logic [9:0] max_x_q;
	logic [9:0] max_y_q;

	assign in_item.from_mouse = s_tuser;
	assign in_item.data_byte  = s_tdata;
	assign cfg_ready          = 1'b1;

	// clamp bound registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= MAX_X_RESET;
			max_y_q <= MAX_Y_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IDX_MAX_X: max_x_q <= cfg_data;
				CFG_IDX_MAX_Y: max_y_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ps2kmd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item_take  (fire),
		.item       (item)
	);

	ps2kmd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item),
		.max_x  (max_x_q),
		.max_y  (max_y_q),
		.result (res)
	);

	ps2kmd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (item_valid),
		.res_fire  (fire),
		.res       (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// output packing
	assign m_tdata = {4'd0, out_res.key_code, out_res.left_button,
	                  out_res.cursor_y, out_res.cursor_x};
	assign m_tuser = out_res.packet_done;

	// a decoded byte always shows up at the output next cycle
	a_fire_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("decoded byte did not reach the output register");

	// input side only backs up behind a stalled result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled while the output was free");

	// a completed packet leaves the cursor inside the clamp bounds
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[9:0] <= max_x_q
		                           && m_tdata[19:10] <= max_y_q))
		else $error("cursor outside clamp bounds after packet");

endmodule
